/* src/sgbp_pkg.sv */
`timescale 1ns / 1ps
package sgbp_pkg;

  localparam int MAX_RADIUS = 6;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int TAP_COUNT  = MAX_RADIUS + 1;
  localparam int IDX_W      = $clog2(WIN_DEPTH);
  localparam int DIST_W     = $clog2(TAP_COUNT);
  localparam int RAD_W      = 3;
  localparam int TAP_W      = 16;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int PROD_W     = TAP_W + CH_W;
  localparam int ACC_W      = PROD_W + $clog2(WIN_DEPTH);
  localparam int WSUM_W     = TAP_W + $clog2(WIN_DEPTH);
  localparam int DVS_W      = WSUM_W + CH_W - 1;
  localparam int STEP_W     = $clog2(CH_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [RAD_W-1:0] RADIUS_RESET     = RAD_W'(3);
  localparam logic [TAP_W-1:0] TAP_CENTER_RESET = {TAP_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS,
    REG_TAP_CENTER,
    REG_TAP_ONE,
    REG_TAP_TWO,
    REG_TAP_THREE,
    REG_TAP_FOUR,
    REG_TAP_FIVE,
    REG_TAP_SIX
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

/* src/sgbp_in_if.sv */
`timescale 1ns / 1ps
interface sgbp_in_if
  import sgbp_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_alpha;
  logic            line_end;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, line_end, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, line_end, output ready);
endinterface

/* src/sgbp_out_if.sv */
`timescale 1ns / 1ps
interface sgbp_out_if
  import sgbp_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  logic            out_last;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, out_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, out_last, output ready);
endinterface

/* src/separable_gaussian_blur_pass_unit.sv */
`timescale 1ns / 1ps
// An accepted pixel with no output frees the input in the next cycle.
// Each output steps the multiply-accumulate through 2R+1 taps, the restoring
// divider over 8 quotient bits, then waits in the output register until taken.
// No new pixel is taken until that output is taken; R = effective radius.
// Reset: synchronous; radius 3, center tap 65535, other taps 0, no line open.
module separable_gaussian_blur_pass_unit
  import sgbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sgbp_in_if.sink               in_ch,
  sgbp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [RAD_W-1:0]  radius_r;
  logic [TAP_W-1:0]  taps_r [TAP_COUNT];
  logic [PIX_W-1:0]  win_r [WIN_DEPTH];
  logic [PIX_W-1:0]  pix_r;
  logic [DIST_W-1:0] pending_r;
  logic              started_r;
  logic              end_r;
  logic              last_r;
  logic [IDX_W-1:0]  mac_idx_r;
  logic [ACC_W-1:0]  acc_r [NUM_CH];
  logic [WSUM_W-1:0] wsum_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [CH_W-1:0]   quo_r [NUM_CH];
  logic [STEP_W-1:0] step_r;

  logic              accept;
  logic              emit_now;
  logic              start_flush_mac;
  logic              mac_done;
  logic [DIST_W-1:0] r_eff;
  logic [DIST_W-1:0] pending_eff;
  logic [IDX_W-1:0]  center;
  logic [IDX_W-1:0]  lo_idx;
  logic [DIST_W-1:0] tap_dist;
  logic [TAP_W-1:0]  weight;
  logic [PIX_W-1:0]  in_pix;
  logic [PIX_W-1:0]  tap_pix;
  logic [WSUM_W-1:0] wsum_nxt;
  logic [PROD_W-1:0] prod [NUM_CH];

  assign r_eff = (int'(radius_r) > MAX_RADIUS) ? DIST_W'(MAX_RADIUS) : DIST_W'(radius_r);
  assign center = IDX_W'(WIN_DEPTH - 1) - IDX_W'(r_eff);
  assign lo_idx = center - IDX_W'(r_eff);
  assign in_pix = {in_ch.in_alpha, in_ch.in_blue, in_ch.in_green, in_ch.in_red};
  assign pending_eff = started_r ? pending_r : '0;

  assign accept   = in_ch.valid && in_ch.ready;
  assign emit_now = pending_eff >= r_eff;
  assign mac_done = (mac_idx_r == IDX_W'(WIN_DEPTH - 1));

  // multiply-accumulate datapath
  assign tap_dist = (mac_idx_r > center) ? DIST_W'(mac_idx_r - center)
                                         : DIST_W'(center - mac_idx_r);
  assign weight  = taps_r[tap_dist];
  assign tap_pix = win_r[mac_idx_r];
  assign wsum_nxt = wsum_r + WSUM_W'(weight);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = weight * tap_pix[c*CH_W +: CH_W];
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    start_flush_mac = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (emit_now) begin
            state_nxt = ST_MAC;
          end else if (in_ch.line_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (pending_r != '0) begin
          start_flush_mac = 1'b1;
          state_nxt       = ST_MAC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = end_r ? ST_FLUSH : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
      for (int t = 0; t < TAP_COUNT; t++) begin
        taps_r[t] <= (t == 0) ? TAP_CENTER_RESET : '0;
      end
    end else if (cfg_we) begin
      if (cfg_reg_t'(cfg_index) == REG_RADIUS) begin
        radius_r <= cfg_data[RAD_W-1:0];
      end else begin
        taps_r[DIST_W'(cfg_index - CFG_IDX_W'(REG_TAP_CENTER))] <= cfg_data[TAP_W-1:0];
      end
    end
  end

  // line control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      pending_r <= '0;
    end else if (accept) begin
      started_r <= !in_ch.line_end;
      pending_r <= emit_now ? pending_eff : pending_eff + DIST_W'(1);
    end else if (start_flush_mac) begin
      pending_r <= pending_r - DIST_W'(1);
    end
  end

  // window, accumulate and divide
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r  <= in_pix;
      end_r  <= in_ch.line_end;
      last_r <= in_ch.line_end && (pending_eff == '0);
      for (int i = 0; i < WIN_DEPTH; i++) begin
        if (!started_r || i == WIN_DEPTH - 1) begin
          win_r[i] <= in_pix;
        end else begin
          win_r[i] <= win_r[i+1];
        end
      end
    end else if (start_flush_mac) begin
      last_r <= (pending_r == DIST_W'(1));
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_DEPTH-1] <= pix_r;
    end

    if ((accept && emit_now) || start_flush_mac) begin
      mac_idx_r <= lo_idx;
      wsum_r    <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        acc_r[c] <= '0;
      end
    end else if (state_r == ST_MAC) begin
      mac_idx_r <= mac_idx_r + IDX_W'(1);
      wsum_r    <= wsum_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod[c]);
      end
      if (mac_done) begin
        dvs_r  <= DVS_W'(wsum_nxt) << (CH_W - 1);
        step_r <= STEP_W'(CH_W - 1);
      end
    end else if (state_r == ST_DIV) begin
      dvs_r  <= dvs_r >> 1;
      step_r <= step_r - STEP_W'(1);
      for (int c = 0; c < NUM_CH; c++) begin
        if (acc_r[c] >= ACC_W'(dvs_r)) begin
          acc_r[c] <= acc_r[c] - ACC_W'(dvs_r);
          quo_r[c] <= {quo_r[c][CH_W-2:0], 1'b1};
        end else begin
          quo_r[c] <= {quo_r[c][CH_W-2:0], 1'b0};
        end
      end
    end
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = (state_r == ST_OUT);
  assign out_ch.out_red   = (wsum_r == '0) ? '0 : quo_r[0];
  assign out_ch.out_green = (wsum_r == '0) ? '0 : quo_r[1];
  assign out_ch.out_blue  = (wsum_r == '0) ? '0 : quo_r[2];
  assign out_ch.out_alpha = (wsum_r == '0) ? '0 : quo_r[3];
  assign out_ch.out_last  = last_r;

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pending_r) <= MAX_RADIUS)
    else $error("pending count beyond window");

  a_mac_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC |-> mac_idx_r >= lo_idx && mac_idx_r <= IDX_W'(WIN_DEPTH - 1))
    else $error("tap index outside kernel span");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.out_last) |-> !started_r && pending_r == '0)
    else $error("last pixel sent with line still open");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.line_end) |=> !in_ch.ready)
    else $error("line end taken without flush");

endmodule
